// ----- rtl/core/cantxq_pkg.sv -----
// Shared types and constants for the CAN transmit slot queue.
package cantxq_pkg;

	localparam int DEF_SLOT_COUNT = 8;
	localparam int NODE_ID_W      = 7;
	localparam int PEAK_W         = 4;
	localparam int PEAK_CALC_W    = 7;

	localparam logic [PEAK_W-1:0] PEAK_MAX   = 4'd15;
	localparam logic [7:0]        SIDH_BASE  = 8'b1011_0000;

	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_SERVICE = 1'b1;

	typedef enum logic [1:0] {
		ST_FREE    = 2'd0,
		ST_OPEN    = 2'd1,
		ST_PENDING = 2'd2
	} slot_st_t;

	typedef struct packed {
		logic [4:0]  sidl_low;
		logic [7:0]  eidh;
		logic [7:0]  eidl;
		logic [7:0]  dlc;
		logic [63:0] data;
	} frame_t;

	typedef struct packed {
		logic enq_hit;
		logic enq_full;
		logic srv_hit;
	} slot_sel_t;

endpackage

// ----- rtl/core/can_tx_slot_queue.sv -----
// Top level of the slotted CAN transmit queue.
// In the cycle an item is accepted the slot search runs, the status
// table is updated and the frame memory is written (enqueue) or read (service); in the
// next cycle the registered memory read data forms the result, which is loaded into the
// output register once that register is free. A new item is accepted once the previous
// one has moved into the output register. Stored frames come back from a synchronous
// memory with a registered read port; slot status lives in flip-flops cleared by reset.
module can_tx_slot_queue #(
	parameter int SLOT_COUNT = cantxq_pkg::DEF_SLOT_COUNT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [cantxq_pkg::NODE_ID_W-1:0] cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic                             tx_busy,
	input  logic [4:0]                       sidl_low_bits,
	input  logic [7:0]                       ext_id_high,
	input  logic [7:0]                       ext_id_low,
	input  logic [7:0]                       length_code,
	input  logic [63:0]                      payload,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             accepted,
	output logic                             queue_full,
	output logic                             frame_valid,
	output logic [7:0]                       frame_sidh,
	output logic [7:0]                       frame_sidl,
	output logic [7:0]                       frame_eidh,
	output logic [7:0]                       frame_eidl,
	output logic [7:0]                       frame_dlc,
	output logic [63:0]                      frame_data,
	output logic [cantxq_pkg::PEAK_W-1:0]    high_water
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [cantxq_pkg::NODE_ID_W-1:0] node_id_q;
	cantxq_pkg::slot_sel_t            sel;
	logic [IDX_W-1:0]                 sel_idx;
	logic [cantxq_pkg::PEAK_W-1:0]    peak;
	cantxq_pkg::frame_t               wr_frame;
	cantxq_pkg::frame_t               rd_frame;
	logic                             in_fire;
	logic                             is_enq;
	logic                             is_srv;
	logic                             out_load;

	logic valid_s1;
	logic acc_s1;
	logic full_s1;
	logic send_s1;

	logic                          out_valid_q;
	logic                          accepted_q;
	logic                          queue_full_q;
	logic                          frame_valid_q;
	logic [7:0]                    frame_sidh_q;
	logic [7:0]                    frame_sidl_q;
	logic [7:0]                    frame_eidh_q;
	logic [7:0]                    frame_eidl_q;
	logic [7:0]                    frame_dlc_q;
	logic [63:0]                   frame_data_q;
	logic [cantxq_pkg::PEAK_W-1:0] high_water_q;

	assign in_ready = !valid_s1;
	assign in_fire  = in_valid && in_ready;
	assign is_enq   = (cmd == cantxq_pkg::CMD_ENQUEUE);
	assign is_srv   = (cmd == cantxq_pkg::CMD_SERVICE) && !tx_busy;
	assign out_load = valid_s1 && (!out_valid_q || out_ready);

	assign wr_frame.sidl_low = sidl_low_bits;
	assign wr_frame.eidh     = ext_id_high;
	assign wr_frame.eidl     = ext_id_low;
	assign wr_frame.dlc      = length_code;
	assign wr_frame.data     = payload;

	cantxq_slot_ctrl #(
		.SLOT_COUNT(SLOT_COUNT),
		.IDX_W     (IDX_W)
	) u_slot_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.cmd    (cmd),
		.tx_busy(tx_busy),
		.sel    (sel),
		.sel_idx(sel_idx),
		.peak   (peak)
	);

	cantxq_frame_mem #(
		.SLOT_COUNT(SLOT_COUNT),
		.IDX_W     (IDX_W)
	) u_frame_mem (
		.clk    (clk),
		.wr_en  (in_fire && is_enq && sel.enq_hit),
		.wr_addr(sel_idx),
		.wr_data(wr_frame),
		.rd_en  (in_fire && is_srv && sel.srv_hit),
		.rd_addr(sel_idx),
		.rd_data(rd_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
		end else if (cfg_wr_en) begin
			node_id_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_s1  <= is_enq && sel.enq_hit;
			full_s1 <= is_enq && sel.enq_full;
			send_s1 <= is_srv && sel.srv_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			accepted_q    <= acc_s1;
			queue_full_q  <= full_s1;
			frame_valid_q <= send_s1;
			high_water_q  <= peak;
			if (send_s1) begin
				frame_sidh_q <= cantxq_pkg::SIDH_BASE | {4'b0000, node_id_q[6:3]};
				frame_sidl_q <= {node_id_q[2:0], rd_frame.sidl_low};
				frame_eidh_q <= rd_frame.eidh;
				frame_eidl_q <= rd_frame.eidl;
				frame_dlc_q  <= rd_frame.dlc;
				frame_data_q <= rd_frame.data;
			end else begin
				frame_sidh_q <= '0;
				frame_sidl_q <= '0;
				frame_eidh_q <= '0;
				frame_eidl_q <= '0;
				frame_dlc_q  <= '0;
				frame_data_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign queue_full  = queue_full_q;
	assign frame_valid = frame_valid_q;
	assign frame_sidh  = frame_sidh_q;
	assign frame_sidl  = frame_sidl_q;
	assign frame_eidh  = frame_eidh_q;
	assign frame_eidl  = frame_eidl_q;
	assign frame_dlc   = frame_dlc_q;
	assign frame_data  = frame_data_q;
	assign high_water  = high_water_q;

endmodule

// ----- rtl/core/cantxq_slot_ctrl.sv -----
// Slot status table with lowest-free and lowest-open search and peak tracking.
module cantxq_slot_ctrl #(
	parameter int SLOT_COUNT = cantxq_pkg::DEF_SLOT_COUNT,
	parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          cmd,
	input  logic                          tx_busy,
	output cantxq_pkg::slot_sel_t         sel,
	output logic [IDX_W-1:0]              sel_idx,
	output logic [cantxq_pkg::PEAK_W-1:0] peak
);

	cantxq_pkg::slot_st_t status_q [SLOT_COUNT];
	logic [cantxq_pkg::PEAK_W-1:0] peak_q;

	logic                          free_hit;
	logic [IDX_W-1:0]              free_idx;
	logic                          open_hit;
	logic [IDX_W-1:0]              open_idx;
	logic [cantxq_pkg::PEAK_CALC_W-1:0] used;
	logic [cantxq_pkg::PEAK_W-1:0] peak_cand;
	logic                          do_enq;
	logic                          do_srv;

	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		open_hit = 1'b0;
		open_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (status_q[i] == cantxq_pkg::ST_FREE) begin
				free_hit = 1'b1;
				free_idx = IDX_W'(i);
			end
			if (status_q[i] == cantxq_pkg::ST_OPEN) begin
				open_hit = 1'b1;
				open_idx = IDX_W'(i);
			end
		end
	end

	assign used      = cantxq_pkg::PEAK_CALC_W'(free_idx) + cantxq_pkg::PEAK_CALC_W'(1);
	assign peak_cand = (used > cantxq_pkg::PEAK_CALC_W'(cantxq_pkg::PEAK_MAX)) ?
		cantxq_pkg::PEAK_MAX : used[cantxq_pkg::PEAK_W-1:0];

	assign do_enq = start && (cmd == cantxq_pkg::CMD_ENQUEUE);
	assign do_srv = start && (cmd == cantxq_pkg::CMD_SERVICE) && !tx_busy;

	assign sel.enq_hit  = free_hit;
	assign sel.enq_full = !free_hit;
	assign sel.srv_hit  = open_hit;
	assign sel_idx      = (cmd == cantxq_pkg::CMD_ENQUEUE) ? free_idx : open_idx;
	assign peak         = peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				status_q[i] <= cantxq_pkg::ST_FREE;
			end
			peak_q <= '0;
		end else begin
			if (do_enq && free_hit) begin
				status_q[free_idx] <= cantxq_pkg::ST_OPEN;
				if (peak_cand > peak_q) begin
					peak_q <= peak_cand;
				end
			end
			if (do_srv) begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (status_q[i] == cantxq_pkg::ST_PENDING) begin
						status_q[i] <= cantxq_pkg::ST_FREE;
					end
				end
				if (open_hit) begin
					status_q[open_idx] <= cantxq_pkg::ST_PENDING;
				end
			end
		end
	end

endmodule

// ----- rtl/core/cantxq_frame_mem.sv -----
// Frame storage memory, one write port and one registered read port.
module cantxq_frame_mem #(
	parameter int SLOT_COUNT = cantxq_pkg::DEF_SLOT_COUNT,
	parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  cantxq_pkg::frame_t  wr_data,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output cantxq_pkg::frame_t  rd_data
);

	cantxq_pkg::frame_t mem [SLOT_COUNT];
	cantxq_pkg::frame_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
